// File: hdl/harrs_pkg.sv
// Shared constants, types and codes for the health-aware round-robin selector.
package harrs_pkg;

    localparam int NUM_BACKENDS = 16;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int CONN_W       = 16;
    localparam int REQ_W        = 32;
    localparam int FAIL_W       = 4;
    localparam int KIND_W       = 3;
    localparam int CFG_DATA_W   = 5;

    localparam logic [FAIL_W-1:0] FAIL_MAX      = 4'd15;
    localparam logic [FAIL_W-1:0] THRESH_RESET  = 4'd3;
    localparam logic [CNT_W-1:0]  BACKENDS_MAX  = 5'd16;
    localparam logic [CONN_W-1:0] CONN_MAX      = '1;
    localparam logic [REQ_W-1:0]  REQ_MAX       = '1;

    localparam logic CFG_BACKENDS  = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_MARKDN  = 3'd2,
        KIND_PROBE   = 3'd3,
        KIND_QUERY   = 3'd4
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load_in;
        logic commit;
    } t_cmd;

endpackage

// File: hdl/harrs_ctrl.sv
// Controller state machine that sequences capture, execution and result hand-off.
module harrs_ctrl
    import harrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_full;
    logic   n_out_full;
    logic   slot_free;

    assign slot_free = !r_out_full || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.commit   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_full = 1'b1;
        end else if (i_out_ready) begin
            n_out_full = 1'b0;
        end else begin
            n_out_full = r_out_full;
        end
    end

    assign o_out_valid = r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

endmodule

// File: hdl/harrs_dp.sv
// Datapath holding the backend table, the round-robin pick and the result register.
module harrs_dp
    import harrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [IDX_W-1:0]      i_backend,
    input  logic                  i_probe_ok,
    output logic                  o_ok,
    output logic [IDX_W-1:0]      o_backend_out,
    output logic                  o_backend_alive,
    output logic [CONN_W-1:0]     o_active_count,
    output logic [REQ_W-1:0]      o_request_total,
    output logic [FAIL_W-1:0]     o_fail_count,
    output logic [CNT_W-1:0]      o_healthy_total
);

    logic [NUM_BACKENDS-1:0] r_alive;
    logic [CONN_W-1:0]       r_active [NUM_BACKENDS];
    logic [REQ_W-1:0]        r_req    [NUM_BACKENDS];
    logic [FAIL_W-1:0]       r_fail   [NUM_BACKENDS];
    logic [IDX_W-1:0]        r_rr;
    logic [CNT_W-1:0]        r_biu;
    logic [FAIL_W-1:0]       r_thr;

    t_kind                   r_kind;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_pok;

    logic                    r_ok;
    logic [IDX_W-1:0]        r_bout;
    logic                    r_balive;
    logic [CONN_W-1:0]       r_bactive;
    logic [REQ_W-1:0]        r_breq;
    logic [FAIL_W-1:0]       r_bfail;
    logic [CNT_W-1:0]        r_healthy;

    logic [CNT_W-1:0]        n_eff;
    logic [NUM_BACKENDS-1:0] use_mask;
    logic [NUM_BACKENDS-1:0] cand;
    logic [NUM_BACKENDS-1:0] cand_hi;
    logic [IDX_W-1:0]        pick_hi;
    logic [IDX_W-1:0]        pick_any;
    logic [IDX_W-1:0]        pick;
    logic                    found;
    logic [CNT_W-1:0]        pick_inc;
    logic [IDX_W-1:0]        n_rr;
    logic                    is_request;
    logic                    idx_valid;
    logic                    do_entry;
    logic [IDX_W-1:0]        tgt;
    logic                    n_alive_e;
    logic [CONN_W-1:0]       n_active_e;
    logic [REQ_W-1:0]        n_req_e;
    logic [FAIL_W-1:0]       n_fail_e;
    logic [FAIL_W-1:0]       fail_inc;
    logic [NUM_BACKENDS-1:0] n_alive;
    logic [CNT_W-1:0]        n_healthy;

    assign n_eff = (r_biu > BACKENDS_MAX) ? BACKENDS_MAX : r_biu;

    always_comb begin
        for (int i = 0; i < NUM_BACKENDS; i++) begin
            use_mask[i] = CNT_W'(i) < n_eff;
            cand[i]     = r_alive[i] && use_mask[i];
            cand_hi[i]  = cand[i] && (IDX_W'(i) >= r_rr);
        end
    end

    always_comb begin
        pick_hi  = '0;
        pick_any = '0;
        for (int i = NUM_BACKENDS - 1; i >= 0; i--) begin
            if (cand_hi[i]) begin
                pick_hi = IDX_W'(i);
            end
            if (cand[i]) begin
                pick_any = IDX_W'(i);
            end
        end
    end

    assign found    = |cand;
    assign pick     = (|cand_hi) ? pick_hi : pick_any;
    assign pick_inc = {1'b0, pick} + CNT_W'(1);
    assign n_rr     = (pick_inc >= n_eff) ? '0 : pick_inc[IDX_W-1:0];

    assign is_request = (r_kind == KIND_REQUEST);
    assign idx_valid  = {1'b0, r_idx} < n_eff;
    assign tgt        = is_request ? pick : r_idx;
    assign fail_inc   = (r_fail[tgt] < FAIL_MAX) ? r_fail[tgt] + FAIL_W'(1) : r_fail[tgt];

    always_comb begin
        n_alive_e  = r_alive[tgt];
        n_active_e = r_active[tgt];
        n_req_e    = r_req[tgt];
        n_fail_e   = r_fail[tgt];
        do_entry   = 1'b0;
        case (r_kind)
            KIND_REQUEST: begin
                do_entry = found;
                if (r_active[tgt] != CONN_MAX) begin
                    n_active_e = r_active[tgt] + CONN_W'(1);
                end
                if (r_req[tgt] != REQ_MAX) begin
                    n_req_e = r_req[tgt] + REQ_W'(1);
                end
            end
            KIND_RELEASE: begin
                do_entry = idx_valid;
                if (r_active[tgt] != '0) begin
                    n_active_e = r_active[tgt] - CONN_W'(1);
                end
            end
            KIND_MARKDN: begin
                do_entry  = idx_valid;
                n_alive_e = 1'b0;
            end
            KIND_PROBE: begin
                do_entry = idx_valid;
                if (r_pok) begin
                    n_alive_e = 1'b1;
                    n_fail_e  = '0;
                end else begin
                    n_fail_e = fail_inc;
                    if (fail_inc >= r_thr) begin
                        n_alive_e = 1'b0;
                    end
                end
            end
            KIND_QUERY: begin
                do_entry = idx_valid;
            end
            default: begin
                do_entry = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_alive = r_alive;
        if (do_entry) begin
            n_alive[tgt] = n_alive_e;
        end
        n_healthy = '0;
        for (int i = 0; i < NUM_BACKENDS; i++) begin
            n_healthy = n_healthy + CNT_W'(n_alive[i] && use_mask[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '1;
            r_rr    <= '0;
            r_biu   <= '0;
            r_thr   <= THRESH_RESET;
            for (int i = 0; i < NUM_BACKENDS; i++) begin
                r_active[i] <= '0;
                r_req[i]    <= '0;
                r_fail[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BACKENDS) begin
                    r_biu <= i_cfg_data;
                    r_rr  <= '0;
                end else begin
                    r_thr <= i_cfg_data[FAIL_W-1:0];
                end
            end
            if (i_cmd.commit && do_entry) begin
                r_alive[tgt]  <= n_alive_e;
                r_active[tgt] <= n_active_e;
                r_req[tgt]    <= n_req_e;
                r_fail[tgt]   <= n_fail_e;
                if (is_request) begin
                    r_rr <= n_rr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= t_kind'(i_kind);
            r_idx  <= i_backend;
            r_pok  <= i_probe_ok;
        end
        if (i_cmd.commit) begin
            r_ok      <= do_entry;
            r_bout    <= tgt;
            r_balive  <= do_entry ? n_alive_e : 1'b0;
            r_bactive <= do_entry ? n_active_e : '0;
            r_breq    <= do_entry ? n_req_e : '0;
            r_bfail   <= do_entry ? n_fail_e : '0;
            r_healthy <= n_healthy;
        end
    end

    assign o_ok            = r_ok;
    assign o_backend_out   = r_bout;
    assign o_backend_alive = r_balive;
    assign o_active_count  = r_bactive;
    assign o_request_total = r_breq;
    assign o_fail_count    = r_bfail;
    assign o_healthy_total = r_healthy;

endmodule

// File: hdl/health_aware_round_robin_selector.sv
// Top level of the health-aware round-robin backend selector.
// A result beat is written to the output register in the exec state that follows the
// capture of its input beat, later while an earlier result still waits in that register.
// Inputs are taken one at a time: the input beat is captured in the idle state, and the
// pick and the update of the backend table take place in the exec state.
// Reset is synchronous and active low: all backends alive, all counters zero,
// round-robin pointer zero, no backends in use, failure threshold three.
module health_aware_round_robin_selector
    import harrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [IDX_W-1:0]      i_backend,
    input  logic                  i_probe_ok,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_ok,
    output logic [IDX_W-1:0]      o_backend_out,
    output logic                  o_backend_alive,
    output logic [CONN_W-1:0]     o_active_count,
    output logic [REQ_W-1:0]      o_request_total,
    output logic [FAIL_W-1:0]     o_fail_count,
    output logic [CNT_W-1:0]      o_healthy_total,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    harrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    harrs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_backend       (i_backend),
        .i_probe_ok      (i_probe_ok),
        .o_ok            (o_ok),
        .o_backend_out   (o_backend_out),
        .o_backend_alive (o_backend_alive),
        .o_active_count  (o_active_count),
        .o_request_total (o_request_total),
        .o_fail_count    (o_fail_count),
        .o_healthy_total (o_healthy_total)
    );

endmodule
